FILE: rtl/assert_macros.svh
// Assertion macros shared by the query term parser modules.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fqtp_pkg.sv
// Types, codes and helper functions of the fuzzy query term parser.
// No dependencies; imported by every module of the block.
package fqtp_pkg;

   // result kinds
   localparam logic [1:0] RK_BODY    = 2'd0;
   localparam logic [1:0] RK_SUMMARY = 2'd1;
   localparam logic [1:0] RK_DONE    = 2'd2;

   // term kinds
   localparam logic [1:0] TK_FUZZY  = 2'd0;
   localparam logic [1:0] TK_EXACT  = 2'd1;
   localparam logic [1:0] TK_PREFIX = 2'd2;
   localparam logic [1:0] TK_SUFFIX = 2'd3;

   // parse phases
   localparam logic [1:0] PH_IDLE  = 2'd0;  // between terms
   localparam logic [1:0] PH_BANG  = 2'd1;  // inverse marker checked
   localparam logic [1:0] PH_QUOTE = 2'd2;  // exact marker checked
   localparam logic [1:0] PH_BODY  = 2'd3;

   // characters
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_CARET  = 8'h5e;
   localparam logic [7:0] CH_DOLLAR = 8'h24;

   localparam int MASK_W     = 36;
   localparam int DIGIT_BASE = 26;

   localparam int QDEPTH = 4;  // power of two
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef struct packed {
      logic [7:0] query_byte;
      logic       byte_present;
      logic       end_of_query;
   } req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [7:0]        term_byte;
      logic [1:0]        term_kind;
      logic              inverse_term;
      logic              pure_ascii;
      logic [MASK_W-1:0] term_char_mask;
      logic [MASK_W-1:0] required_mask;
      logic              last_result;
   } rsp_type;

   // all results caused by one item, in delivery order
   typedef struct packed {
      logic              b0_valid;
      logic [7:0]        b0_byte;
      logic              b1_valid;
      logic [7:0]        b1_byte;
      logic              sum_valid;
      logic [1:0]        sum_kind;
      logic              sum_inverse;
      logic              sum_ascii;
      logic [MASK_W-1:0] sum_mask;
      logic              done_valid;
      logic [MASK_W-1:0] done_mask;
   } cmd_type;

   function automatic logic [MASK_W-1:0] char_bit(input logic [7:0] c);
      logic [MASK_W-1:0] r;
      r = '0;
      if (c inside {[8'h61:8'h7a]}) begin
         r = MASK_W'(1) << (c - 8'h61);
      end else if (c inside {[8'h41:8'h5a]}) begin
         r = MASK_W'(1) << (c - 8'h41);
      end else if (c inside {[8'h30:8'h39]}) begin
         r = MASK_W'(1) << (6'(DIGIT_BASE) + 6'(c - 8'h30));
      end
      return r;
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c, input logic keep);
      logic [7:0] r;
      r = c;
      if (!keep && (c inside {[8'h41:8'h5a]})) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

FILE: rtl/fqtp_front.sv
// Front end: parses one query byte per item and packs its results into one command.
// Depends on fqtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fqtp_front import fqtp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    case_sensitive,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    q_full,
   output logic    push,
   output cmd_type push_cmd
);

   logic [1:0]        phase_ff, phase_in;
   logic [7:0]        held_byte_ff, held_byte_in;
   logic              held_valid_ff, held_valid_in;
   logic              inverse_ff, inverse_in;
   logic              exact_ff, exact_in;
   logic              prefix_ff, prefix_in;
   logic              nonempty_ff, nonempty_in;
   logic              ascii_ff, ascii_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [MASK_W-1:0] required_ff, required_in;

   logic       accept;
   logic       is_sep;
   logic [7:0] low_byte;
   logic [1:0] phase_eff;
   logic       close_now;
   logic       suffix;
   cmd_type    cmd;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_sep    = (req_data.query_byte == CH_SPACE) || (req_data.query_byte == CH_TAB);
   assign low_byte  = fold_case(req_data.query_byte, case_sensitive);
   assign phase_eff = (phase_ff == PH_IDLE) ? PH_BANG : phase_ff;

   always_comb begin
      phase_in      = phase_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      inverse_in    = inverse_ff;
      exact_in      = exact_ff;
      prefix_in     = prefix_ff;
      nonempty_in   = nonempty_ff;
      ascii_in      = ascii_ff;
      mask_in       = mask_ff;
      required_in   = required_ff;
      cmd           = '0;
      suffix        = 1'b0;

      // byte part: markers or body, separators handled by the close below
      if (req_data.byte_present && !is_sep) begin
         if (phase_ff == PH_IDLE && req_data.query_byte == CH_BANG) begin
            inverse_in = 1'b1;
            phase_in   = PH_BANG;
         end else if (phase_eff == PH_BANG && req_data.query_byte == CH_QUOTE) begin
            exact_in = 1'b1;
            phase_in = PH_QUOTE;
         end else if ((phase_eff == PH_BANG || phase_eff == PH_QUOTE) &&
                      req_data.query_byte == CH_CARET) begin
            prefix_in = 1'b1;
            phase_in  = PH_BODY;
         end else begin
            phase_in = PH_BODY;
            if (held_valid_ff) begin
               cmd.b0_valid = 1'b1;
               cmd.b0_byte  = held_byte_ff;
               nonempty_in  = 1'b1;
               if (held_byte_ff[7]) begin
                  ascii_in = 1'b0;
               end
               mask_in = mask_in | char_bit(held_byte_ff);
            end
            held_byte_in  = low_byte;
            held_valid_in = 1'b1;
         end
      end

      close_now = (req_data.byte_present && is_sep && phase_ff != PH_IDLE) ||
                  (req_data.end_of_query && phase_in != PH_IDLE);

      if (close_now) begin
         if (held_valid_in) begin
            if (held_byte_in == CH_DOLLAR) begin
               suffix = 1'b1;
            end else begin
               if (cmd.b0_valid) begin
                  cmd.b1_valid = 1'b1;
                  cmd.b1_byte  = held_byte_in;
               end else begin
                  cmd.b0_valid = 1'b1;
                  cmd.b0_byte  = held_byte_in;
               end
               nonempty_in = 1'b1;
               if (held_byte_in[7]) begin
                  ascii_in = 1'b0;
               end
               mask_in = mask_in | char_bit(held_byte_in);
            end
         end
         cmd.sum_valid = 1'b1;
         if (prefix_in && suffix) begin
            cmd.sum_kind = TK_EXACT;
         end else if (prefix_in) begin
            cmd.sum_kind = TK_PREFIX;
         end else if (suffix) begin
            cmd.sum_kind = TK_SUFFIX;
         end else begin
            cmd.sum_kind = exact_in ? TK_EXACT : TK_FUZZY;
         end
         cmd.sum_inverse = inverse_in;
         cmd.sum_ascii   = ascii_in;
         cmd.sum_mask    = mask_in;
         if (!inverse_in && nonempty_in) begin
            required_in = required_in | mask_in;
         end
      end

      if (close_now || req_data.end_of_query) begin
         phase_in      = PH_IDLE;
         held_byte_in  = '0;
         held_valid_in = 1'b0;
         inverse_in    = 1'b0;
         exact_in      = 1'b0;
         prefix_in     = 1'b0;
         nonempty_in   = 1'b0;
         ascii_in      = 1'b1;
         mask_in       = '0;
      end

      if (req_data.end_of_query) begin
         cmd.done_valid = 1'b1;
         cmd.done_mask  = required_in;
         required_in    = '0;
      end
   end

   assign push     = accept && (cmd.b0_valid || cmd.b1_valid || cmd.sum_valid || cmd.done_valid);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         inverse_ff    <= 1'b0;
         exact_ff      <= 1'b0;
         prefix_ff     <= 1'b0;
         nonempty_ff   <= 1'b0;
         ascii_ff      <= 1'b1;
         mask_ff       <= '0;
         required_ff   <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         inverse_ff    <= inverse_in;
         exact_ff      <= exact_in;
         prefix_ff     <= prefix_in;
         nonempty_ff   <= nonempty_in;
         ascii_ff      <= ascii_in;
         mask_ff       <= mask_in;
         required_ff   <= required_in;
      end
   end

   `ASSERT_NEXT(a_eoq_idle, clock, reset, accept && req_data.end_of_query,
                phase_ff == PH_IDLE && !held_valid_ff && required_ff == '0,
                "front: query end did not return parser to idle")
   `ASSERT_IMPL(a_held_body, clock, reset, held_valid_ff, phase_ff == PH_BODY,
                "front: held byte outside term body")

endmodule

FILE: rtl/fqtp_queue.sv
// Small command queue between the parser front and the result sequencer.
// Depends on fqtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fqtp_queue import fqtp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMPL(a_no_overflow, clock, reset, full, !push,
                "queue: push into full queue")
   `ASSERT_IMPL(a_no_underflow, clock, reset, !head_valid, !pop,
                "queue: pop from empty queue")

endmodule

FILE: rtl/fqtp_back.sv
// Back end: walks one queued command's results out through the output register.
// Depends on fqtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fqtp_back import fqtp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  cmd_type head_cmd,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [3:0] sent_ff, sent_in;  // results of the head already delivered
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic [3:0] pend;
   logic [3:0] pick;
   logic [3:0] rest;
   logic       load;

   assign pend = {head_cmd.done_valid, head_cmd.sum_valid,
                  head_cmd.b1_valid, head_cmd.b0_valid} & ~sent_ff;
   assign pick = pend & (~pend + 4'd1);
   assign rest = pend & ~pick;
   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && (rest == '0);

   always_comb begin
      rsp_data_in  = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sent_in      = sent_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (pick[0]) begin
            rsp_data_in.result_kind = RK_BODY;
            rsp_data_in.term_byte   = head_cmd.b0_byte;
         end else if (pick[1]) begin
            rsp_data_in.result_kind = RK_BODY;
            rsp_data_in.term_byte   = head_cmd.b1_byte;
         end else if (pick[2]) begin
            rsp_data_in.result_kind    = RK_SUMMARY;
            rsp_data_in.term_kind      = head_cmd.sum_kind;
            rsp_data_in.inverse_term   = head_cmd.sum_inverse;
            rsp_data_in.pure_ascii     = head_cmd.sum_ascii;
            rsp_data_in.term_char_mask = head_cmd.sum_mask;
         end else begin
            rsp_data_in.result_kind   = RK_DONE;
            rsp_data_in.required_mask = head_cmd.done_mask;
         end
         rsp_data_in.last_result = (rest == '0);
         sent_in = (rest == '0) ? '0 : (sent_ff | pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPL(a_head_has_work, clock, reset, head_valid, pend != '0,
                "back: queued command with nothing left to deliver")
   `ASSERT_NEXT(a_pop_marks_last, clock, reset, pop,
                rsp_valid_ff && rsp_data_ff.last_result,
                "back: command retired without a last result")

endmodule

FILE: rtl/fuzzy_query_term_parser.sv
// Fuzzy query term parser, top level: front parser, command queue, result sequencer.
// Depends on fqtp_pkg, fqtp_front, fqtp_queue and fqtp_back.
//
// Streams a search query one byte per req item and splits it into terms.
// Space and tab separate terms; a term may open with '!' (inverse), then a
// quote (exact), then '^' (prefix anchor); a trailing '$' marks a suffix
// anchor, and both anchors together mean exact. Body bytes come out one per
// rsp item (ASCII letters lowercased unless case_sensitive is set), each term
// end gives a summary item (kind, inverse, pure ASCII, 36-bit letter/digit
// mask), and end_of_query gives a done item carrying the OR of the masks of
// the non-inverse, non-empty terms. last_result flags the final rsp item of
// each req item; a req item may give no rsp item at all. Timing: the front
// parses an item in the cycle it is accepted, so req items go in one per
// cycle while the queue has room; the output register delivers one rsp item
// per cycle unless rsp_ready is low, so the results of one item (at most
// four) leave one after another, and a four-entry queue between the two sides
// absorbs such bursts. When idle, an accepted item's first rsp item passes
// through a queue entry, then the output register. No clearing pass after
// reset. csr_data is the case_sensitive bit; write it only while the block is idle.

module fuzzy_query_term_parser import fqtp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   // query bytes
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   // parsed results
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   // case_sensitive register
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic    case_sensitive_ff;

   logic    q_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         case_sensitive_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case_sensitive_ff <= csr_data;
      end
   end

   // front: parse state and per-item result packing
   fqtp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .case_sensitive (case_sensitive_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .q_full         (q_full),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // decouples parsing from result delivery
   fqtp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // back: one result per cycle into the output register while the output is not stalled
   fqtp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: verif/fuzzy_query_term_parser_test.sv
// Self-checking bench for fuzzy_query_term_parser: query bytes in, parsed term items out.
// Depends on fqtp_pkg and the RTL; an in-bench tracker rebuilds the term parse
// and every result item is compared against it.
module fuzzy_query_term_parser_test import fqtp_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   // Tracks the parse of the query stream and holds the result items still owed.
   class term_parse_tracker;
      localparam logic [7:0] UP_A = 8'h41, UP_Z = 8'h5a;
      localparam logic [7:0] LOW_A = 8'h61, LOW_Z = 8'h7a;
      localparam logic [7:0] DIG_0 = 8'h30, DIG_9 = 8'h39;

      bit                case_keep;
      logic [1:0]        phase;
      logic [7:0]        held;
      bit                held_ok, inv, quoted, caret, nonempty, ascii_only;
      logic [MASK_W-1:0] tmask, query_mask;
      rsp_type           due_results[$];
      int                errors, checked, summaries, query_ends;

      function new();
         case_keep = 1'b0;
         phase = PH_IDLE;
         query_mask = '0;
         clear_term();
      endfunction

      function void clear_term();
         held = '0;
         held_ok = 0;
         inv = 0;
         quoted = 0;
         caret = 0;
         nonempty = 0;
         ascii_only = 1;
         tmask = '0;
      endfunction

      function void owe_result(rsp_type r);
         due_results.insert(due_results.size(), r);
      endfunction

      function logic [MASK_W-1:0] letter_digit_bit(logic [7:0] c);
         if (c >= LOW_A && c <= LOW_Z) return MASK_W'(1) << (c - LOW_A);
         if (c >= UP_A && c <= UP_Z) return MASK_W'(1) << (c - UP_A);
         if (c >= DIG_0 && c <= DIG_9) return MASK_W'(1) << (DIGIT_BASE + int'(c - DIG_0));
         return '0;
      endfunction

      function void emit_body(logic [7:0] c);
         rsp_type r;
         r = '0;
         r.result_kind = RK_BODY;
         r.term_byte = c;
         nonempty = 1;
         if (c[7]) ascii_only = 0;
         tmask |= letter_digit_bit(c);
         owe_result(r);
      endfunction

      function void close_term();
         bit      suffix;
         rsp_type r;
         suffix = 0;
         if (held_ok) begin
            if (held == CH_DOLLAR) suffix = 1;
            else emit_body(held);
            held_ok = 0;
         end
         r = '0;
         r.result_kind = RK_SUMMARY;
         // both anchors collapse to exact; a suffix alone wins over a quote
         if (caret && suffix) r.term_kind = TK_EXACT;
         else if (caret) r.term_kind = TK_PREFIX;
         else if (suffix) r.term_kind = TK_SUFFIX;
         else r.term_kind = quoted ? TK_EXACT : TK_FUZZY;
         r.inverse_term = inv;
         r.pure_ascii = ascii_only;
         r.term_char_mask = tmask;
         if (!inv && nonempty) query_mask |= tmask;
         owe_result(r);
         clear_term();
         phase = PH_IDLE;
      endfunction

      function void take_byte(logic [7:0] c);
         bit         sep;
         logic [7:0] b;
         sep = (c == CH_SPACE || c == CH_TAB);
         b = c;
         if (phase == PH_IDLE) begin
            if (sep) return;
            phase = PH_BANG;
            if (b == CH_BANG) begin
               inv = 1;
               return;
            end
         end
         if (sep) begin
            close_term();
            return;
         end
         if (phase == PH_BANG) begin
            phase = PH_QUOTE;
            if (b == CH_QUOTE) begin
               quoted = 1;
               return;
            end
         end
         if (phase == PH_QUOTE) begin
            phase = PH_BODY;
            if (b == CH_CARET) begin
               caret = 1;
               return;
            end
         end
         if (!case_keep && b >= UP_A && b <= UP_Z) b = b - UP_A + LOW_A;
         // one-byte hold so a trailing '$' can be recognized at term end
         if (held_ok) emit_body(held);
         held = b;
         held_ok = 1;
      endfunction

      function void take_item(req_type it);
         int      owed_at_entry;
         rsp_type r;
         owed_at_entry = due_results.size();
         if (it.byte_present) take_byte(it.query_byte);
         if (it.end_of_query) begin
            if (phase != PH_IDLE) close_term();
            r = '0;
            r.result_kind = RK_DONE;
            r.required_mask = query_mask;
            owe_result(r);
            query_mask = '0;
            phase = PH_IDLE;
            clear_term();
         end
         if (due_results.size() > owed_at_entry)
            due_results[due_results.size() - 1].last_result = 1'b1;
      endfunction

      function void compare(string field, logic [MASK_W-1:0] want, logic [MASK_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            $error("result_kind: expected no item, got %0d", got.result_kind);
            errors++;
            return;
         end
         want = due_results.pop_front();
         checked++;
         if (want.result_kind == RK_SUMMARY) summaries++;
         if (want.result_kind == RK_DONE) query_ends++;
         compare("result_kind", want.result_kind, got.result_kind);
         compare("term_byte", want.term_byte, got.term_byte);
         compare("term_kind", want.term_kind, got.term_kind);
         compare("inverse_term", want.inverse_term, got.inverse_term);
         compare("pure_ascii", want.pure_ascii, got.pure_ascii);
         compare("term_char_mask", want.term_char_mask, got.term_char_mask);
         compare("required_mask", want.required_mask, got.required_mask);
         compare("last_result", want.last_result, got.last_result);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   term_parse_tracker tracker;
   int items_sent = 0;
   int hold_request = 0;  // long rsp stall asked of the sink, in cycles
   int send_calm = 0;     // items left in a stretch with no gaps
   bit flood = 0;         // no gaps at all while the sink is held off

   fuzzy_query_term_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gap before the next req item: mostly none, some short, a few long,
   // and now and then a run of back-to-back items.
   function automatic int next_gap();
      int pick;
      if (flood) return 0;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
         send_calm = $urandom_range(15, 40);
         return 0;
      end
      if (pick < 62) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic req_type make_item(logic [7:0] b, logic present, logic last);
      req_type it;
      it.query_byte = b;
      it.byte_present = present;
      it.end_of_query = last;
      return it;
   endfunction

   // Body bytes lean on letters and digits but include high bytes, markers
   // out of place and arbitrary values (which may split terms).
   function automatic logic [7:0] body_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) return 8'h61 + 8'($urandom_range(25));
      if (pick < 48) return 8'h41 + 8'($urandom_range(25));
      if (pick < 63) return 8'h30 + 8'($urandom_range(9));
      if (pick < 73) return 8'($urandom_range(8'h80, 8'hff));
      if (pick < 81) begin
         case ($urandom_range(3))
            0: return CH_BANG;
            1: return CH_QUOTE;
            2: return CH_CARET;
            default: return CH_DOLLAR;
         endcase
      end
      if (pick < 90) return 8'($urandom_range(255));
      return 8'($urandom_range(33, 126));
   endfunction

   // Hold valid across back-to-back items; drop it only when a gap follows.
   task automatic send_item(input req_type it);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      tracker.take_item(it);
      if (it.byte_present || it.end_of_query) items_sent++;
   endtask

   task automatic send_text(input string s, input bit close_query);
      for (int i = 0; i < s.len(); i++)
         send_item(make_item(s[i], 1'b1, close_query && i == s.len() - 1));
   endtask

   // Mostly well-formed terms with random markers and bodies, ended either
   // on the last byte or by a bare end item; ignored items sprinkled in.
   task automatic send_random_query();
      logic [7:0] text[$];
      int         nterms;
      bit         bare_end;
      nterms = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 4);
      for (int t = 0; t < nterms; t++) begin
         repeat ($urandom_range(2))
            text.insert(text.size(), $urandom_range(1) ? CH_SPACE : CH_TAB);
         if ($urandom_range(2) == 0) text.insert(text.size(), CH_BANG);
         if ($urandom_range(2) == 0) text.insert(text.size(), CH_QUOTE);
         if ($urandom_range(2) == 0) text.insert(text.size(), CH_CARET);
         repeat ($urandom_range(6)) text.insert(text.size(), body_char());
         if ($urandom_range(2) == 0) text.insert(text.size(), CH_DOLLAR);
         if (t < nterms - 1 || $urandom_range(1))
            text.insert(text.size(), $urandom_range(1) ? CH_SPACE : CH_TAB);
      end
      bare_end = (text.size() == 0) || $urandom_range(1);
      foreach (text[i]) begin
         if ($urandom_range(15) == 0) send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
         send_item(make_item(text[i], 1'b1, !bare_end && i == text.size() - 1));
      end
      if (bare_end) send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
   endtask

   task automatic send_random_queries(input int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) send_random_query();
   endtask

   // Register write only once the block has drained; a trailing item may
   // cause no result, so allow the pipeline latency on top.
   task automatic set_case_mode(input bit keep);
      req_valid <= 1'b0;
      while (tracker.due_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= keep;
      do @(posedge clock); while (!csr_ready);
      tracker.case_keep = keep;
      csr_valid <= 1'b0;
   endtask

   // Result sink: checks each accepted item and picks its own stalls.
   initial begin : result_sink
      int stall_left;
      int sink_calm;
      int pick;
      stall_left = 0;
      sink_calm = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_data);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
            sink_calm = 0;
         end else if (stall_left == 0 && sink_calm == 0) begin
            pick = $urandom_range(99);
            if (pick < 6) sink_calm = $urandom_range(20, 60);
            else if (pick < 24)
               stall_left = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (sink_calm > 0) sink_calm--;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every marker, both anchors, suffix after quote, empty terms,
      // byte extremes, a no-op item, end with and without a byte, and an
      // item that causes four results
      set_case_mode(1'b0);
      send_text("\t!'^Az9$ ", 1'b0);
      send_text("'x$ ", 1'b0);
      send_text("! ", 1'b0);
      send_text("$ ", 1'b0);
      send_item(make_item(8'h00, 1'b1, 1'b0));
      send_item(make_item(8'hff, 1'b1, 1'b0));
      send_item(make_item(8'h00, 1'b0, 1'b1));
      send_item(make_item(8'ha5, 1'b0, 1'b0));
      send_item(make_item(CH_CARET, 1'b1, 1'b1));
      send_text("ab", 1'b0);
      send_item(make_item(8'h63, 1'b1, 1'b1));

      // random phases across both case modes
      set_case_mode(1'b1);
      send_random_queries(120);
      set_case_mode(1'b0);
      send_random_queries(120);
      // long sink stall while items keep coming back to back
      hold_request = 150;
      flood = 1;
      send_random_queries(40);
      flood = 0;
      set_case_mode(1'b1);
      send_random_queries(100);
      set_case_mode(1'($urandom_range(1)));
      send_random_queries(100);

      req_valid <= 1'b0;
      while (tracker.due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d query items in both case modes, with random gaps and a long rsp stall.",
               items_sent);
      $display("Checked %0d result items, %0d term summaries, %0d query ends.",
               tracker.checked, tracker.summaries, tracker.query_ends);
      if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: fuzzy_query_term_parser.f
+incdir+rtl
rtl/fqtp_pkg.sv
rtl/fqtp_front.sv
rtl/fqtp_queue.sv
rtl/fqtp_back.sv
rtl/fuzzy_query_term_parser.sv
verif/fuzzy_query_term_parser_test.sv
